// ===== src/maxwellian_distribution_eval_top_defines.svh =====
// Assertion macros for the checker.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef MAXWELLIAN_DISTRIBUTION_EVAL_TOP_DEFINES_SVH
`define MAXWELLIAN_DISTRIBUTION_EVAL_TOP_DEFINES_SVH

// same-cycle implication
`define MDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent delayed by dly
`define MDE_ASSERT_LATER(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

// ===== src/mde_pkg.sv =====
package mde_pkg;

    localparam int FRAC_BITS      = 20;
    localparam int EXP_LIMIT_LOG2 = 6;
    localparam int CAP_BITS       = EXP_LIMIT_LOG2 + FRAC_BITS;
    localparam int E2_W           = 8;
    localparam int RS_W           = 10;
    localparam int SQRT_STEPS     = 32;
    localparam int CORE_STEPS     = (CAP_BITS > SQRT_STEPS) ? CAP_BITS : SQRT_STEPS;
    localparam int Y_W            = CAP_BITS + 29;
    localparam int K_W            = Y_W - (FRAC_BITS + 28);
    localparam int EXP_TERMS      = 12;
    localparam int EXP_STAGES     = 3 * EXP_TERMS;
    localparam int G_W            = 36;
    localparam int FRONT_STAGES   = 6;
    localparam int MID_STAGES     = 2 + EXP_STAGES;
    localparam int BACK_STAGES    = 3;
    localparam int PIPE_LAT       = FRONT_STAGES + CORE_STEPS + MID_STAGES + BACK_STAGES;

    localparam logic [28:0] LOG2E_Q28  = 29'h1715_4765;
    localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
    localparam logic [29:0] TWO_PI_Q27 = 30'h3243_F6A9;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_TZERO = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0]        density;
        logic [31:0]        temperature;
        logic signed [31:0] mean_vel;
        logic [31:0]        b_field;
        logic signed [31:0] vpar;
        logic [31:0]        mu;
    } t_in;

    typedef struct packed {
        logic [31:0] value;
        t_status     status;
    } t_out;

    // front end: energy numerator, temperature normalization, m * 2pi
    typedef struct packed {
        logic [31:0]            n;
        logic [31:0]            t;
        logic [31:0]            mu;
        logic [31:0]            b;
        logic [31:0]            ad;
        logic [63:0]            sq;
        logic [63:0]            mb;
        logic [64:0]            num;
        logic [31:0]            tn;
        logic [4:0]             lz;
        logic                   zero;
        logic                   under;
        logic [32:0]            mq;
        logic signed [E2_W-1:0] e2;
        logic [62:0]            a;
    } t_fr;

    // energy division and square root
    typedef struct packed {
        logic [31:0]            n;
        logic [31:0]            t;
        logic                   zero;
        logic                   under;
        logic [31:0]            r;
        logic [CAP_BITS-1:0]    q;
        logic [CAP_BITS-1:0]    lo;
        logic [63:0]            x;
        logic [63:0]            res;
        logic [30:0]            ahi;
        logic signed [E2_W-1:0] e2;
    } t_cs;

    // exp series and reciprocal
    typedef struct packed {
        logic [31:0]            n;
        logic                   zero;
        logic                   under;
        logic signed [E2_W-1:0] e2;
        logic [Y_W-1:0]         y;
        logic [62:0]            ddraw;
        logic signed [RS_W-1:0] rs;
        logic [31:0]            t;
        logic [32:0]            term;
        logic [31:0]            x;
        logic [31:0]            qp;
        logic signed [35:0]     sum;
        logic [31:0]            dd;
        logic [31:0]            gr;
        logic [G_W-1:0]         g;
    } t_xs;

    // final scaling
    typedef struct packed {
        logic                   zero;
        logic                   under;
        logic signed [RS_W-1:0] rs;
        logic [31:0]            n;
        logic [64:0]            egraw;
        logic [63:0]            p;
    } t_bs;

    // floor(2^32 / idx) for the series divisors
    function automatic logic [32:0] recip(input int idx);
        logic [32:0] v;
        case (idx)
            2:       v = 33'h0_8000_0000;
            3:       v = 33'h0_5555_5555;
            4:       v = 33'h0_4000_0000;
            5:       v = 33'h0_3333_3333;
            6:       v = 33'h0_2AAA_AAAA;
            7:       v = 33'h0_2492_4924;
            8:       v = 33'h0_2000_0000;
            9:       v = 33'h0_1C71_C71C;
            10:      v = 33'h0_1999_9999;
            11:      v = 33'h0_1745_D174;
            12:      v = 33'h0_1555_5555;
            default: v = 33'h1_0000_0000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/mde_front.sv =====
module mde_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mde_pkg::t_in  i_pt,
    output logic          o_vld,
    output mde_pkg::t_fr  o_fr
);
    import mde_pkg::*;

    logic [FRONT_STAGES-1:0] r_v;
    t_fr                     r_f [FRONT_STAGES];
    t_fr                     n_f [FRONT_STAGES];

    logic [32:0]             d;
    logic [32:0]             dabs;
    logic signed [E2_W-1:0]  e2v;

    always_comb begin
        // stage 0: |vpar - U|, first normalize step
        n_f[0]       = '0;
        n_f[0].n     = i_pt.density;
        n_f[0].t     = i_pt.temperature;
        n_f[0].mu    = i_pt.mu;
        n_f[0].b     = i_pt.b_field;
        d            = {i_pt.vpar[31], i_pt.vpar} - {i_pt.mean_vel[31], i_pt.mean_vel};
        dabs         = d[32] ? (33'd0 - d) : d;
        n_f[0].ad    = dabs[31:0];
        n_f[0].zero  = (i_pt.temperature == 32'h0);
        if (i_pt.temperature[31:16] == 16'h0) begin
            n_f[0].tn = {i_pt.temperature[15:0], 16'h0};
            n_f[0].lz = 5'd16;
        end else begin
            n_f[0].tn = i_pt.temperature;
            n_f[0].lz = 5'd0;
        end

        // stage 1: products
        n_f[1]    = r_f[0];
        n_f[1].sq = {32'h0, r_f[0].ad} * {32'h0, r_f[0].ad};
        n_f[1].mb = {32'h0, r_f[0].mu} * {32'h0, r_f[0].b};
        if (r_f[0].tn[31:24] == 8'h0) begin
            n_f[1].tn = {r_f[0].tn[23:0], 8'h0};
            n_f[1].lz = r_f[0].lz | 5'd8;
        end

        // stage 2: numerator = sq/2 + mu*B
        n_f[2]     = r_f[1];
        n_f[2].num = {2'b0, r_f[1].sq[63:1]} + {1'b0, r_f[1].mb};
        if (r_f[1].tn[31:28] == 4'h0) begin
            n_f[2].tn = {r_f[1].tn[27:0], 4'h0};
            n_f[2].lz = r_f[1].lz | 5'd4;
        end

        // stage 3: quotient would reach the cap
        n_f[3]       = r_f[2];
        n_f[3].under = (r_f[2].num[64:CAP_BITS] >= r_f[2].t);
        if (r_f[2].tn[31:30] == 2'h0) begin
            n_f[3].tn = {r_f[2].tn[29:0], 2'h0};
            n_f[3].lz = r_f[2].lz | 5'd2;
        end

        // stage 4: last normalize step, even exponent
        n_f[4] = r_f[3];
        if (!r_f[3].tn[31]) begin
            n_f[4].tn = {r_f[3].tn[30:0], 1'b0};
            n_f[4].lz = r_f[3].lz | 5'd1;
        end
        e2v = E2_W'(31 - FRAC_BITS) - E2_W'(n_f[4].lz);
        if (e2v[0]) begin
            n_f[4].mq = {n_f[4].tn, 1'b0};
            n_f[4].e2 = e2v - E2_W'(1);
        end else begin
            n_f[4].mq = {1'b0, n_f[4].tn};
            n_f[4].e2 = e2v;
        end

        // stage 5: a = m * 2pi
        n_f[5]   = r_f[4];
        n_f[5].a = {30'h0, r_f[4].mq} * {33'h0, TWO_PI_Q27};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FRONT_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_f <= n_f;
    end

    assign o_vld = r_v[FRONT_STAGES-1];
    assign o_fr  = r_f[FRONT_STAGES-1];

endmodule

// ===== src/mde_root_div.sv =====
module mde_root_div (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mde_pkg::t_fr  i_fr,
    output logic          o_vld,
    output mde_pkg::t_cs  o_cs
);
    import mde_pkg::*;

    logic [CORE_STEPS-1:0] r_v;
    t_cs                   r_c [CORE_STEPS];
    t_cs                   n_c [CORE_STEPS];

    t_cs                   cur;
    logic [32:0]           rr;
    logic [63:0]           bitv;
    logic [63:0]           trial;

    // one root bit per stage, and one quotient bit in each of the first CAP_BITS stages
    always_comb begin
        for (int j = 0; j < CORE_STEPS; j++) begin
            if (j == 0) begin
                cur       = '0;
                cur.n     = i_fr.n;
                cur.t     = i_fr.t;
                cur.zero  = i_fr.zero;
                cur.under = i_fr.under;
                cur.e2    = i_fr.e2;
                cur.r     = 32'(i_fr.num[64:CAP_BITS]);
                cur.lo    = i_fr.num[CAP_BITS-1:0];
                cur.x     = {1'b0, i_fr.a};
                cur.res   = 64'h0;
                cur.ahi   = i_fr.a[62:32];
            end else begin
                cur = r_c[j-1];
            end
            rr    = '0;
            bitv  = '0;
            trial = '0;
            if (j < CAP_BITS) begin
                rr = {cur.r, cur.lo[CAP_BITS-1]};
                if (rr >= {1'b0, cur.t}) begin
                    rr    = rr - {1'b0, cur.t};
                    cur.q = {cur.q[CAP_BITS-2:0], 1'b1};
                end else begin
                    cur.q = {cur.q[CAP_BITS-2:0], 1'b0};
                end
                cur.r  = rr[31:0];
                cur.lo = {cur.lo[CAP_BITS-2:0], 1'b0};
            end
            if (j < SQRT_STEPS) begin
                bitv  = 64'h1 << (62 - 2 * j);
                trial = cur.res + bitv;
                if (cur.x >= trial) begin
                    cur.x   = cur.x - trial;
                    cur.res = (cur.res >> 1) + bitv;
                end else begin
                    cur.res = cur.res >> 1;
                end
            end
            n_c[j] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[CORE_STEPS-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
    end

    assign o_vld = r_v[CORE_STEPS-1];
    assign o_cs  = r_c[CORE_STEPS-1];

endmodule

// ===== src/mde_exp_rcp.sv =====
module mde_exp_rcp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mde_pkg::t_cs  i_cs,
    output logic          o_vld,
    output mde_pkg::t_xs  o_xs
);
    import mde_pkg::*;

    logic [MID_STAGES-1:0]  r_v;
    t_xs                    r_x [MID_STAGES];
    t_xs                    n_x [MID_STAGES];

    t_xs                    cur;
    logic [K_W-1:0]         kv;
    logic [31:0]            fr;
    logic [63:0]            prod;
    logic [64:0]            prod2;
    logic [35:0]            qi;
    logic [35:0]            rem;
    logic [31:0]            qf;
    logic signed [RS_W-1:0] e2x;
    logic signed [RS_W-1:0] e3;
    logic signed [RS_W-1:0] e3h;
    logic [32:0]            grr;

    always_comb begin : p_next
        int ti;
        int sub;
        ti    = 1;
        sub   = 0;
        kv    = '0;
        fr    = '0;
        prod  = '0;
        prod2 = '0;
        qi    = '0;
        rem   = '0;
        qf    = '0;
        e2x   = '0;
        e3    = '0;
        e3h   = '0;
        grr   = '0;
        for (int j = 0; j < MID_STAGES; j++) begin
            if (j == 0) begin
                // log2(e) scaling and D = (a>>32) * sqrt(a)
                cur       = '0;
                cur.n     = i_cs.n;
                cur.zero  = i_cs.zero;
                cur.under = i_cs.under;
                cur.e2    = i_cs.e2;
                cur.y     = Y_W'(i_cs.q) * Y_W'(LOG2E_Q28);
                cur.ddraw = 63'(i_cs.ahi) * 63'(i_cs.res[31:0]);
            end else if (j == 1) begin
                cur      = r_x[0];
                kv       = cur.y[Y_W-1:FRAC_BITS+28];
                fr       = cur.y[FRAC_BITS+27:FRAC_BITS-4];
                prod     = 64'(fr) * 64'(LN2_Q32);
                cur.t    = prod[63:32];
                cur.dd   = (cur.ddraw[62:31] == 32'h0) ? 32'h1 : cur.ddraw[62:31];
                e2x      = RS_W'(cur.e2);
                e3       = e2x + (e2x <<< 1);
                e3h      = e3 >>> 1;
                cur.rs   = RS_W'(35) + RS_W'(kv) + e3h;
                cur.term = 33'h1_0000_0000;
                cur.sum  = 36'sh1_0000_0000;
                cur.gr   = 32'(64'h1 << (63 - G_W));
                cur.g    = '0;
            end else begin
                cur = r_x[j-1];
                // series term ti: multiply, reciprocal, correct and accumulate
                case (sub)
                    0: begin
                        prod  = 64'(cur.term) * 64'(cur.t);
                        cur.x = prod[63:32];
                    end
                    1: begin
                        prod2  = 65'(cur.x) * 65'(recip(ti));
                        cur.qp = prod2[63:32];
                    end
                    default: begin
                        qi  = 36'(cur.qp) * 36'(ti);
                        rem = 36'(cur.x) - qi;
                        qf  = (rem >= 36'(ti)) ? cur.qp + 32'h1 : cur.qp;
                        cur.term = {1'b0, qf};
                        if (ti % 2 == 1) begin
                            cur.sum = cur.sum - 36'(cur.term);
                        end else begin
                            cur.sum = cur.sum + 36'(cur.term);
                        end
                    end
                endcase
                if (sub == 2) begin
                    sub = 0;
                    ti  = ti + 1;
                end else begin
                    sub = sub + 1;
                end
                // reciprocal 2^63 / D, one quotient bit a stage
                if (j - 2 < G_W) begin
                    grr = {cur.gr, 1'b0};
                    if (grr >= {1'b0, cur.dd}) begin
                        grr   = grr - {1'b0, cur.dd};
                        cur.g = {cur.g[G_W-2:0], 1'b1};
                    end else begin
                        cur.g = {cur.g[G_W-2:0], 1'b0};
                    end
                    cur.gr = grr[31:0];
                end
            end
            n_x[j] = cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[MID_STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
    end

    assign o_vld = r_v[MID_STAGES-1];
    assign o_xs  = r_x[MID_STAGES-1];

endmodule

// ===== src/mde_back.sv =====
module mde_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  mde_pkg::t_xs  i_xs,
    output logic          o_stb,
    output mde_pkg::t_out o_res
);
    import mde_pkg::*;

    logic        r_v1;
    logic        r_v2;
    logic        r_stb;
    t_bs         r_b1;
    t_bs         r_b2;
    t_out        r_out;
    t_bs         n_b1;
    t_bs         n_b2;
    t_out        n_out;

    logic [32:0] em;
    logic [32:0] eg;
    logic [63:0] ps;
    logic [95:0] wide;
    logic [4:0]  ls;

    always_comb begin
        // clamp exp(-t) to [1, 2^32], scale by the reciprocal
        if (i_xs.sum < 36'sd1) begin
            em = 33'h1;
        end else if (i_xs.sum > 36'sh1_0000_0000) begin
            em = 33'h1_0000_0000;
        end else begin
            em = i_xs.sum[32:0];
        end
        n_b1       = '0;
        n_b1.zero  = i_xs.zero;
        n_b1.under = i_xs.under;
        n_b1.rs    = i_xs.rs;
        n_b1.n     = i_xs.n;
        n_b1.egraw = 65'(em[32:4]) * 65'(i_xs.g);

        n_b2   = r_b1;
        eg     = r_b1.egraw[64:32];
        n_b2.p = 64'(r_b1.n) * 64'(eg);

        // final shift and saturation; zero temperature and underflow give a zero value
        ps    = '0;
        wide  = '0;
        ls    = '0;
        n_out = '0;
        n_out.status = ST_OK;
        if (r_b2.zero) begin
            n_out.status = ST_TZERO;
        end else if (r_b2.under) begin
            n_out.value = 32'h0;
        end else if (!r_b2.rs[RS_W-1]) begin
            if (r_b2.rs[RS_W-2:6] == '0) begin
                ps = r_b2.p >> r_b2.rs[5:0];
                if (ps[63:32] != 32'h0) begin
                    n_out.value  = 32'hFFFF_FFFF;
                    n_out.status = ST_SAT;
                end else begin
                    n_out.value = ps[31:0];
                end
            end
        end else begin
            ls   = 5'(RS_W'(0) - r_b2.rs);
            wide = {32'h0, r_b2.p} << ls;
            if (wide[95:32] != 64'h0) begin
                n_out.value  = 32'hFFFF_FFFF;
                n_out.status = ST_SAT;
            end else begin
                n_out.value = wide[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_stb <= 1'b0;
        end else begin
            r_v1  <= i_vld;
            r_v2  <= r_v1;
            r_stb <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1  <= n_b1;
        r_b2  <= n_b2;
        r_out <= n_out;
    end

    assign o_stb = r_stb;
    assign o_res = r_out;

endmodule

// ===== src/maxwellian_distribution_eval_top.sv =====
// Channel   Handshake        Payload
// -------   --------------   -------------------------------------
// point     start / busy     i_point  (mde_pkg::t_in, six fields)
// result    o_strobe         o_result (mde_pkg::t_out, value/status)
//
// One point accepted per cycle while busy is low; every point gives one result beat.
// The pipeline depth is set mostly by the 32-step
// division/square-root pipeline and the 12-term exp series at 3 stages a term.
// Synchronous active-low reset clears the valid bits; busy is high during
// reset and until r_rdy is set after it, and low otherwise.
// The result side has no back-pressure, so the pipeline never stalls.
module maxwellian_distribution_eval_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mde_pkg::t_in  i_point,
    output mde_pkg::t_out o_result,
    output logic          o_strobe
);
    import mde_pkg::*;

    logic r_rdy;
    logic acc;
    logic fr_vld;
    logic cs_vld;
    logic xs_vld;
    t_fr  fr;
    t_cs  cs;
    t_xs  xs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy = !(r_rdy && i_rst_n);
    assign acc  = start && !busy;

    mde_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (acc),
        .i_pt    (i_point),
        .o_vld   (fr_vld),
        .o_fr    (fr)
    );

    mde_root_div u_root_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (fr_vld),
        .i_fr    (fr),
        .o_vld   (cs_vld),
        .o_cs    (cs)
    );

    mde_exp_rcp u_exp_rcp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cs_vld),
        .i_cs    (cs),
        .o_vld   (xs_vld),
        .o_xs    (xs)
    );

    mde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (xs_vld),
        .i_xs    (xs),
        .o_stb   (o_strobe),
        .o_res   (o_result)
    );

endmodule

// ===== src/mde_checker.sv =====
`include "maxwellian_distribution_eval_top_defines.svh"

module mde_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input mde_pkg::t_in  i_point,
    input mde_pkg::t_out o_result,
    input logic          o_strobe
);
    import mde_pkg::*;

    // every accepted point comes out as a result beat
    `MDE_ASSERT_LATER(a_beat_out, start && !busy, PIPE_LAT, o_strobe, "result beat missing")

    // and no beat appears without one
    `MDE_ASSERT_NOW(a_no_extra, o_strobe, $past(start && !busy, PIPE_LAT), "unexpected result beat")

    `MDE_ASSERT_LATER(a_tzero, start && !busy && i_point.temperature == 32'h0, PIPE_LAT, o_result.status == ST_TZERO && o_result.value == 32'h0, "zero temperature not flagged")

    `MDE_ASSERT_NOW(a_sat, o_strobe && o_result.status == ST_SAT, o_result.value == 32'hFFFF_FFFF, "saturated beat not at full scale")

endmodule

bind maxwellian_distribution_eval_top mde_checker u_chk (.*);
